// ===== hw/rtl/rtss_pkg.sv =====
`timescale 1ns / 1ps
package rtss_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int NAME_CHUNKS = 4;
  localparam int CSEL_W      = 2;
  localparam int NADDR_W     = IDX_W + CSEL_W;
  localparam int CHUNK_W     = 64;
  localparam int AGE_W       = 8;
  localparam int AVG_W       = 14;
  localparam int SUM_W       = 18;
  localparam int STEP_W      = 5;

  typedef enum logic [2:0] {
    OP_STAGE  = 3'd0,
    OP_APPEND = 3'd1,
    OP_LIST   = 3'd2,
    OP_SORT   = 3'd3,
    OP_SEARCH = 3'd4,
    OP_READ   = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    STS_DONE      = 3'd0,
    STS_APPENDED  = 3'd1,
    STS_FULL      = 3'd2,
    STS_FOUND     = 3'd3,
    STS_NOT_FOUND = 3'd4,
    STS_ENTRY     = 3'd5,
    STS_GROUP_AVG = 3'd6,
    STS_EMPTY     = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPEND,
    ST_RES,
    ST_SORT_RI,
    ST_SORT_LD,
    ST_SORT_J,
    ST_SORT_WB,
    ST_LIST_RD,
    ST_LIST_EM,
    ST_DIV,
    ST_SRCH_REC,
    ST_SRCH_PH,
    ST_SRCH_CMP,
    ST_RD_PH,
    ST_RD_EM
  } state_t;

  typedef enum logic [1:0] {
    CMP_CONT,
    CMP_MATCH,
    CMP_MISS
  } cmp_t;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic [AVG_W-1:0] avg;
    logic [IDX_W-1:0] phys;
  } rec_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/record_table_sort_search_unit.sv =====
`timescale 1ns / 1ps
// Stage and unused opcodes give their result directly; append writes the name chunks;
// read chunk reads the record, then the chunk. List: each entry, then the group average
// from the 18-step divider. Sort: compared pairs and a write-back per outer pass on
// the record memory, then the list. Search: each entry's record, then its chunks.
// One item at a time; reset clears the entry count, staged name and control
// state; the record and name memories are not cleared.
module record_table_sort_search_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [1:0]  in_chunk_select,
  input  logic [63:0] in_name_chunk,
  input  logic [7:0]  in_age,
  input  logic [13:0] in_average_hundredths,
  input  logic [3:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_result_index,
  output logic [7:0]  out_result_age,
  output logic [13:0] out_result_average,
  output logic [63:0] out_result_chunk,
  output logic [4:0]  out_entry_count,
  output logic        out_last
);

  localparam int IW = rtss_pkg::IDX_W;
  localparam int CW = rtss_pkg::CNT_W;
  localparam int SW = rtss_pkg::CSEL_W;

  function automatic rtss_pkg::cmp_t chunk_cmp(input logic [63:0] a, input logic [63:0] b);
    rtss_pkg::cmp_t res;
    logic           hit;
    res = rtss_pkg::CMP_CONT;
    hit = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!hit) begin
        if (a[8*k +: 8] != b[8*k +: 8]) begin
          res = rtss_pkg::CMP_MISS;
          hit = 1'b1;
        end else if (a[8*k +: 8] == 8'd0) begin
          res = rtss_pkg::CMP_MATCH;
          hit = 1'b1;
        end
      end
    end
    return res;
  endfunction

  rtss_pkg::state_t  state_r, state_nxt;

  // memories
  rtss_pkg::rec_t    rec_mem [rtss_pkg::TABLE_DEPTH];
  logic [63:0]       name_mem [rtss_pkg::TABLE_DEPTH*rtss_pkg::NAME_CHUNKS];
  rtss_pkg::rec_t    rec_rd_r;
  logic [63:0]       name_rd_r;
  logic              rec_we, rec_re, name_we, name_re;
  logic [IW-1:0]     rec_wa, rec_ra;
  rtss_pkg::rec_t    rec_wd;
  logic [rtss_pkg::NADDR_W-1:0] name_wa, name_ra;
  logic [63:0]       name_wd;

  // latched input
  logic [2:0]        op_r;
  logic [SW-1:0]     cs_r;
  logic [7:0]        age_r;
  logic [13:0]       avg_r;
  logic [IW-1:0]     ei_r;
  logic [63:0]       stage_r [rtss_pkg::NAME_CHUNKS];

  // control
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     i_r, i_nxt, j_r, j_nxt, e_r, e_nxt;
  logic [SW-1:0]     c_r, c_nxt;
  rtss_pkg::rec_t    ri_r, ri_nxt;
  logic [rtss_pkg::SUM_W-1:0] sum_r, sum_nxt;
  rtss_pkg::status_t res_status_r, res_status_nxt;
  logic [IW-1:0]     res_index_r, res_index_nxt;
  logic [7:0]        res_age_r, res_age_nxt;
  logic [13:0]       res_avg_r, res_avg_nxt;

  // output register
  logic              out_valid_r;
  rtss_pkg::status_t out_status_r, out_status_nxt;
  logic [IW-1:0]     out_index_r, out_index_nxt;
  logic [7:0]        out_age_r, out_age_nxt;
  logic [13:0]       out_avg_r, out_avg_nxt;
  logic [63:0]       out_chunk_r, out_chunk_nxt;
  logic [CW-1:0]     out_count_r;
  logic              out_last_r, out_last_nxt;
  logic              out_load;

  logic              in_fire, slot_free, full, empty, oob, swap, j_more, e_more;
  logic              sort_more, found;
  rtss_pkg::cmp_t    cmp_res;
  logic              div_start;
  logic [rtss_pkg::SUM_W-1:0] div_quot;
  rtss_pkg::div_stat_t div_stat;

  assign in_ready  = (state_r == rtss_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign full      = (cnt_r == CW'(rtss_pkg::TABLE_DEPTH));
  assign empty     = (cnt_r == '0);
  assign oob       = ({1'b0, in_entry_index} >= cnt_r);
  assign swap      = (ri_r.avg < rec_rd_r.avg);
  assign j_more    = ((j_r + CW'(1)) < cnt_r);
  assign e_more    = ((e_r + CW'(1)) < cnt_r);
  assign sort_more = ((i_r + CW'(2)) < cnt_r);
  assign cmp_res   = chunk_cmp(stage_r[c_r], name_rd_r);
  assign found     = (cmp_res == rtss_pkg::CMP_MATCH) ||
                     (cmp_res == rtss_pkg::CMP_CONT && c_r == SW'(rtss_pkg::NAME_CHUNKS-1));

  rtss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (cnt_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtss_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (rtss_pkg::opcode_t'(in_opcode))
            rtss_pkg::OP_STAGE:  state_nxt = rtss_pkg::ST_RES;
            rtss_pkg::OP_APPEND: state_nxt = full ? rtss_pkg::ST_RES : rtss_pkg::ST_APPEND;
            rtss_pkg::OP_LIST:   state_nxt = empty ? rtss_pkg::ST_RES : rtss_pkg::ST_LIST_RD;
            rtss_pkg::OP_SORT: begin
              if (empty)                state_nxt = rtss_pkg::ST_RES;
              else if (cnt_r < CW'(2))  state_nxt = rtss_pkg::ST_LIST_RD;
              else                      state_nxt = rtss_pkg::ST_SORT_RI;
            end
            rtss_pkg::OP_SEARCH: state_nxt = empty ? rtss_pkg::ST_RES : rtss_pkg::ST_SRCH_REC;
            rtss_pkg::OP_READ:   state_nxt = oob ? rtss_pkg::ST_RES : rtss_pkg::ST_RD_PH;
            default:             state_nxt = rtss_pkg::ST_RES;
          endcase
        end
      end
      rtss_pkg::ST_APPEND:
        if (c_r == SW'(rtss_pkg::NAME_CHUNKS-1)) state_nxt = rtss_pkg::ST_RES;
      rtss_pkg::ST_RES:     if (slot_free) state_nxt = rtss_pkg::ST_IDLE;
      rtss_pkg::ST_SORT_RI: state_nxt = rtss_pkg::ST_SORT_LD;
      rtss_pkg::ST_SORT_LD: state_nxt = rtss_pkg::ST_SORT_J;
      rtss_pkg::ST_SORT_J:  if (!j_more) state_nxt = rtss_pkg::ST_SORT_WB;
      rtss_pkg::ST_SORT_WB:
        state_nxt = sort_more ? rtss_pkg::ST_SORT_RI : rtss_pkg::ST_LIST_RD;
      rtss_pkg::ST_LIST_RD: state_nxt = rtss_pkg::ST_LIST_EM;
      rtss_pkg::ST_LIST_EM:
        if (slot_free) state_nxt = e_more ? rtss_pkg::ST_LIST_RD : rtss_pkg::ST_DIV;
      rtss_pkg::ST_DIV:      if (div_stat.done) state_nxt = rtss_pkg::ST_RES;
      rtss_pkg::ST_SRCH_REC: state_nxt = rtss_pkg::ST_SRCH_PH;
      rtss_pkg::ST_SRCH_PH:  state_nxt = rtss_pkg::ST_SRCH_CMP;
      rtss_pkg::ST_SRCH_CMP: begin
        if (found)                               state_nxt = rtss_pkg::ST_RES;
        else if (cmp_res == rtss_pkg::CMP_MISS)
          state_nxt = e_more ? rtss_pkg::ST_SRCH_REC : rtss_pkg::ST_RES;
      end
      rtss_pkg::ST_RD_PH: state_nxt = rtss_pkg::ST_RD_EM;
      rtss_pkg::ST_RD_EM: if (slot_free) state_nxt = rtss_pkg::ST_IDLE;
      default:            state_nxt = rtss_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    e_nxt          = e_r;
    c_nxt          = c_r;
    ri_nxt         = ri_r;
    sum_nxt        = sum_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_age_nxt    = res_age_r;
    res_avg_nxt    = res_avg_r;
    rec_we  = 1'b0;
    rec_re  = 1'b0;
    rec_wa  = '0;
    rec_ra  = '0;
    rec_wd  = ri_r;
    name_we = 1'b0;
    name_re = 1'b0;
    name_wa = '0;
    name_ra = '0;
    name_wd = stage_r[c_r];
    out_load       = 1'b0;
    out_status_nxt = res_status_r;
    out_index_nxt  = res_index_r;
    out_age_nxt    = res_age_r;
    out_avg_nxt    = res_avg_r;
    out_chunk_nxt  = '0;
    out_last_nxt   = 1'b1;
    div_start      = 1'b0;
    unique case (state_r)
      rtss_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_status_nxt = rtss_pkg::STS_DONE;
          res_index_nxt  = '0;
          res_age_nxt    = '0;
          res_avg_nxt    = '0;
          e_nxt          = '0;
          i_nxt          = '0;
          c_nxt          = '0;
          sum_nxt        = '0;
          unique case (rtss_pkg::opcode_t'(in_opcode))
            rtss_pkg::OP_APPEND: if (full) res_status_nxt = rtss_pkg::STS_FULL;
            rtss_pkg::OP_LIST, rtss_pkg::OP_SORT:
              if (empty) res_status_nxt = rtss_pkg::STS_EMPTY;
            rtss_pkg::OP_SEARCH: if (empty) res_status_nxt = rtss_pkg::STS_NOT_FOUND;
            rtss_pkg::OP_READ: begin
              if (oob) begin
                res_status_nxt = rtss_pkg::STS_NOT_FOUND;
              end else begin
                rec_re = 1'b1;
                rec_ra = in_entry_index;
              end
            end
            default: ;
          endcase
        end
      end
      rtss_pkg::ST_APPEND: begin
        name_we = 1'b1;
        name_wa = {cnt_r[IW-1:0], c_r};
        if (c_r == '0) begin
          rec_we = 1'b1;
          rec_wa = cnt_r[IW-1:0];
          rec_wd = '{age: age_r, avg: avg_r, phys: cnt_r[IW-1:0]};
        end
        c_nxt = c_r + SW'(1);
        if (c_r == SW'(rtss_pkg::NAME_CHUNKS-1)) begin
          cnt_nxt        = cnt_r + CW'(1);
          res_status_nxt = rtss_pkg::STS_APPENDED;
        end
      end
      rtss_pkg::ST_RES: out_load = slot_free;
      rtss_pkg::ST_SORT_RI: begin
        rec_re = 1'b1;
        rec_ra = i_r[IW-1:0];
      end
      rtss_pkg::ST_SORT_LD: begin
        ri_nxt = rec_rd_r;
        j_nxt  = i_r + CW'(1);
        rec_re = 1'b1;
        rec_ra = j_nxt[IW-1:0];
      end
      rtss_pkg::ST_SORT_J: begin
        // keep the larger average in hand, put the smaller back at j
        if (swap) begin
          rec_we = 1'b1;
          rec_wa = j_r[IW-1:0];
          rec_wd = ri_r;
          ri_nxt = rec_rd_r;
        end
        if (j_more) begin
          j_nxt  = j_r + CW'(1);
          rec_re = 1'b1;
          rec_ra = j_nxt[IW-1:0];
        end
      end
      rtss_pkg::ST_SORT_WB: begin
        rec_we = 1'b1;
        rec_wa = i_r[IW-1:0];
        rec_wd = ri_r;
        i_nxt  = i_r + CW'(1);
      end
      rtss_pkg::ST_LIST_RD: begin
        rec_re = 1'b1;
        rec_ra = e_r[IW-1:0];
      end
      rtss_pkg::ST_LIST_EM: begin
        out_status_nxt = rtss_pkg::STS_ENTRY;
        out_index_nxt  = e_r[IW-1:0];
        out_age_nxt    = rec_rd_r.age;
        out_avg_nxt    = rec_rd_r.avg;
        out_last_nxt   = 1'b0;
        if (slot_free) begin
          out_load = 1'b1;
          sum_nxt  = sum_r + rtss_pkg::SUM_W'(rec_rd_r.avg);
          e_nxt    = e_r + CW'(1);
          div_start = !e_more;
        end
      end
      rtss_pkg::ST_DIV: begin
        if (div_stat.done) begin
          res_status_nxt = rtss_pkg::STS_GROUP_AVG;
          res_avg_nxt    = div_quot[rtss_pkg::AVG_W-1:0];
        end
      end
      rtss_pkg::ST_SRCH_REC: begin
        rec_re = 1'b1;
        rec_ra = e_r[IW-1:0];
      end
      rtss_pkg::ST_SRCH_PH: begin
        name_re = 1'b1;
        name_ra = {rec_rd_r.phys, SW'(0)};
        c_nxt   = '0;
      end
      rtss_pkg::ST_SRCH_CMP: begin
        if (found) begin
          res_status_nxt = rtss_pkg::STS_FOUND;
          res_index_nxt  = e_r[IW-1:0];
          res_age_nxt    = rec_rd_r.age;
          res_avg_nxt    = rec_rd_r.avg;
        end else if (cmp_res == rtss_pkg::CMP_MISS) begin
          e_nxt = e_r + CW'(1);
          if (!e_more) res_status_nxt = rtss_pkg::STS_NOT_FOUND;
        end else begin
          c_nxt   = c_r + SW'(1);
          name_re = 1'b1;
          name_ra = {rec_rd_r.phys, c_nxt};
        end
      end
      rtss_pkg::ST_RD_PH: begin
        name_re = 1'b1;
        name_ra = {rec_rd_r.phys, cs_r};
      end
      rtss_pkg::ST_RD_EM: begin
        out_status_nxt = rtss_pkg::STS_DONE;
        out_index_nxt  = ei_r;
        out_age_nxt    = '0;
        out_avg_nxt    = '0;
        out_chunk_nxt  = name_rd_r;
        out_load       = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (rec_re) rec_rd_r <= rec_mem[rec_ra];
  end

  always_ff @(posedge clk) begin
    if (name_we) name_mem[name_wa] <= name_wd;
    if (name_re) name_rd_r <= name_mem[name_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtss_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < rtss_pkg::NAME_CHUNKS; k++) stage_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (in_fire && in_opcode == rtss_pkg::OP_STAGE) stage_r[in_chunk_select] <= in_name_chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_opcode;
      cs_r  <= in_chunk_select;
      age_r <= in_age;
      avg_r <= in_average_hundredths;
      ei_r  <= in_entry_index;
    end
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    e_r          <= e_nxt;
    c_r          <= c_nxt;
    ri_r         <= ri_nxt;
    sum_r        <= sum_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_age_r    <= res_age_nxt;
    res_avg_r    <= res_avg_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_index_r  <= out_index_nxt;
      out_age_r    <= out_age_nxt;
      out_avg_r    <= out_avg_nxt;
      out_chunk_r  <= out_chunk_nxt;
      out_count_r  <= cnt_r;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_index   = out_index_r;
  assign out_result_age     = out_age_r;
  assign out_result_average = out_avg_r;
  assign out_result_chunk   = out_chunk_r;
  assign out_entry_count    = out_count_r;
  assign out_last           = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken transfer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(rtss_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rtss_pkg::ST_APPEND) |=> (cnt_r == $past(cnt_r)))
    else $error("entry count moved outside append");

  a_rec_port: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_we && rec_re) |-> (rec_wa != rec_ra))
    else $error("record read and write hit the same entry");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_op_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtss_pkg::ST_APPEND) |-> (op_r == rtss_pkg::OP_APPEND))
    else $error("append sequence without append opcode");

endmodule

// ===== hw/rtl/rtss_div.sv =====
`timescale 1ns / 1ps
module rtss_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rtss_pkg::SUM_W-1:0] dividend,
  input  logic [rtss_pkg::CNT_W-1:0] divisor,
  output logic [rtss_pkg::SUM_W-1:0] quotient,
  output rtss_pkg::div_stat_t        stat
);

  logic [rtss_pkg::SUM_W-1:0]  quo_r;
  logic [rtss_pkg::CNT_W-1:0]  rem_r;
  logic [rtss_pkg::STEP_W-1:0] step_r;
  logic                        busy_r;
  logic                        done_r;
  logic [rtss_pkg::CNT_W:0]    trial;
  logic [rtss_pkg::CNT_W:0]    diff;
  logic                        fits;

  assign trial = {rem_r, quo_r[rtss_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == rtss_pkg::STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      step_r <= rtss_pkg::STEP_W'(rtss_pkg::SUM_W);
    end else if (busy_r) begin
      quo_r  <= {quo_r[rtss_pkg::SUM_W-2:0], fits};
      rem_r  <= fits ? diff[rtss_pkg::CNT_W-1:0] : trial[rtss_pkg::CNT_W-1:0];
      step_r <= step_r - rtss_pkg::STEP_W'(1);
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== tb/sv/record_table_checker.sv =====
`timescale 1ns / 1ps
module record_table_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [1:0]  in_chunk_select,
  input  logic [63:0] in_name_chunk,
  input  logic [7:0]  in_age,
  input  logic [13:0] in_average_hundredths,
  input  logic [3:0]  in_entry_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [3:0]  out_result_index,
  input  logic [7:0]  out_result_age,
  input  logic [13:0] out_result_average,
  input  logic [63:0] out_result_chunk,
  input  logic [4:0]  out_entry_count,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_results
);

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  index;
    logic [7:0]  age;
    logic [13:0] avg;
    logic [63:0] chunk;
    logic [4:0]  count;
    logic        last;
  } table_result_t;

  table_result_t result_q[$];

  logic [63:0] name_mem[rtss_pkg::TABLE_DEPTH][rtss_pkg::NAME_CHUNKS];
  logic [7:0]  age_mem[rtss_pkg::TABLE_DEPTH];
  logic [13:0] avg_mem[rtss_pkg::TABLE_DEPTH];
  logic [4:0]  held;
  logic [63:0] staged[rtss_pkg::NAME_CHUNKS];

  assign pending_results = result_q.size();

  function automatic table_result_t mk(logic [2:0] st, logic [3:0] idx, logic [7:0] ag,
                                       logic [13:0] av, logic [63:0] ch, logic lst);
    table_result_t r;
    r.status = st; r.index = idx; r.age = ag; r.avg = av; r.chunk = ch;
    r.count = held; r.last = lst;
    return r;
  endfunction

  function automatic bit staged_matches(int e);
    logic [7:0] a, b;
    for (int k = 0; k < rtss_pkg::NAME_CHUNKS * 8; k++) begin
      a = staged[k / 8][(k % 8) * 8 +: 8];
      b = name_mem[e][k / 8][(k % 8) * 8 +: 8];
      if (a != b) return 0;
      if (a == 8'd0) return 1;
    end
    return 1;
  endfunction

  task automatic push_listing();
    logic [17:0] sum;
    sum = '0;
    if (held == 0) begin
      result_q.push_back(mk(rtss_pkg::STS_EMPTY, 0, 0, 0, 0, 1));
      return;
    end
    for (int e = 0; e < held; e++) begin
      result_q.push_back(mk(rtss_pkg::STS_ENTRY, e[3:0], age_mem[e], avg_mem[e], 0, 0));
      sum += avg_mem[e];
    end
    result_q.push_back(mk(rtss_pkg::STS_GROUP_AVG, 0, 0, 14'(sum / held), 0, 1));
  endtask

  task automatic predict_table_op();
    logic [63:0] tn;
    logic [7:0]  ta;
    logic [13:0] tv;
    bit hit;
    hit = 0;
    case (in_opcode)
      rtss_pkg::OP_STAGE: begin
        staged[in_chunk_select] = in_name_chunk;
        result_q.push_back(mk(rtss_pkg::STS_DONE, 0, 0, 0, 0, 1));
      end
      rtss_pkg::OP_APPEND: begin
        if (held >= rtss_pkg::TABLE_DEPTH)
          result_q.push_back(mk(rtss_pkg::STS_FULL, 0, 0, 0, 0, 1));
        else begin
          for (int c = 0; c < rtss_pkg::NAME_CHUNKS; c++) name_mem[held][c] = staged[c];
          age_mem[held] = in_age;
          avg_mem[held] = in_average_hundredths;
          held++;
          result_q.push_back(mk(rtss_pkg::STS_APPENDED, 0, 0, 0, 0, 1));
        end
      end
      rtss_pkg::OP_LIST: push_listing();
      rtss_pkg::OP_SORT: begin
        for (int i = 0; i + 1 < held; i++)
          for (int j = i + 1; j < held; j++)
            if (avg_mem[i] < avg_mem[j]) begin
              ta = age_mem[i]; age_mem[i] = age_mem[j]; age_mem[j] = ta;
              tv = avg_mem[i]; avg_mem[i] = avg_mem[j]; avg_mem[j] = tv;
              for (int c = 0; c < rtss_pkg::NAME_CHUNKS; c++) begin
                tn = name_mem[i][c]; name_mem[i][c] = name_mem[j][c]; name_mem[j][c] = tn;
              end
            end
        push_listing();
      end
      rtss_pkg::OP_SEARCH: begin
        for (int e = 0; e < held && !hit; e++)
          if (staged_matches(e)) begin
            hit = 1;
            result_q.push_back(mk(rtss_pkg::STS_FOUND, e[3:0], age_mem[e], avg_mem[e], 0, 1));
          end
        if (!hit) result_q.push_back(mk(rtss_pkg::STS_NOT_FOUND, 0, 0, 0, 0, 1));
      end
      rtss_pkg::OP_READ: begin
        if (in_entry_index >= held)
          result_q.push_back(mk(rtss_pkg::STS_NOT_FOUND, 0, 0, 0, 0, 1));
        else result_q.push_back(mk(rtss_pkg::STS_DONE, in_entry_index, 0, 0,
                                   name_mem[in_entry_index][in_chunk_select], 1));
      end
      default: result_q.push_back(mk(rtss_pkg::STS_DONE, 0, 0, 0, 0, 1));
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    held = 0;
    for (int c = 0; c < rtss_pkg::NAME_CHUNKS; c++) staged[c] = '0;
  end

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result, status %0d", out_status);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          check_field("status", want.status, out_status);
          check_field("result_index", want.index, out_result_index);
          check_field("result_age", want.age, out_result_age);
          check_field("result_average", want.avg, out_result_average);
          check_field("result_chunk", want.chunk, out_result_chunk);
          check_field("entry_count", want.count, out_entry_count);
          check_field("last", want.last, out_last);
        end
      end
      if (in_valid && in_ready) predict_table_op();
    end
  end

endmodule

// ===== tb/sv/tb_record_table_sort_search_unit.sv =====
`timescale 1ns / 1ps
module tb_record_table_sort_search_unit;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_opcode;
  logic [1:0]  in_chunk_select;
  logic [63:0] in_name_chunk;
  logic [7:0]  in_age;
  logic [13:0] in_average_hundredths;
  logic [3:0]  in_entry_index;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [3:0]  out_result_index;
  logic [7:0]  out_result_age;
  logic [13:0] out_result_average;
  logic [63:0] out_result_chunk;
  logic [4:0]  out_entry_count;
  logic        out_last;
  int          fail_count;
  int          pending_results;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  int  quiet_cycles;
  logic [63:0] name_pool[4];

  localparam int QUIET_LIMIT = 20000;

  record_table_sort_search_unit dut (.*);
  record_table_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // valid stays up after a transfer until the next call or a drain drops it
  task automatic send_op(logic [2:0] op, logic [1:0] cs, logic [63:0] nc, logic [7:0] ag,
                         logic [13:0] av, logic [3:0] ei);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_chunk_select <= cs;
    in_name_chunk <= nc;
    in_age <= ag;
    in_average_hundredths <= av;
    in_entry_index <= ei;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // a name chunk with a terminator somewhere, or none at all
  function automatic logic [63:0] random_chunk();
    logic [63:0] v;
    int cut;
    v = {$urandom, $urandom};
    cut = $urandom_range(9);
    if (cut < 8) v = v & ~(64'hFFFF_FFFF_FFFF_FFFF << (cut * 8));
    return v;
  endfunction

  task automatic random_item();
    int r;
    logic [1:0] cs;
    r = $urandom_range(99);
    cs = 2'($urandom_range(3));
    if (r < 30) begin
      if ($urandom_range(1))
        send_op(rtss_pkg::OP_STAGE, cs, name_pool[$urandom_range(3)], 0, 0, 0);
      else send_op(rtss_pkg::OP_STAGE, cs, random_chunk(), 0, 0, 0);
    end else if (r < 52)
      send_op(rtss_pkg::OP_APPEND, cs, 0, 8'($urandom), 14'($urandom_range(10000)), 0);
    else if (r < 60) send_op(rtss_pkg::OP_LIST, cs, 0, 0, 0, 0);
    else if (r < 66) send_op(rtss_pkg::OP_SORT, cs, 0, 0, 0, 0);
    else if (r < 80) send_op(rtss_pkg::OP_SEARCH, cs, 0, 0, 0, 0);
    else if (r < 95) send_op(rtss_pkg::OP_READ, cs, 0, 0, 0, 4'($urandom));
    else if (r < 97) send_op(3'(6 + $urandom_range(1)), cs, {$urandom, $urandom},
                             8'($urandom), 14'($urandom), 4'($urandom));
    else send_op(rtss_pkg::OP_APPEND, cs, 0, 8'($urandom),
                 14'(16383 - $urandom_range(6383)), 0);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_opcode = rtss_pkg::OP_STAGE;
    in_chunk_select = 0;
    in_name_chunk = 0;
    in_age = 0;
    in_average_hundredths = 0;
    in_entry_index = 0;
    out_ready = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    for (int i = 0; i < 4; i++) name_pool[i] = random_chunk();
    repeat (5) @(negedge clk);
    rst_n = 1;

    // directed: empty table, extremes, fill past full, sort, search, reads
    send_op(rtss_pkg::OP_LIST, 0, 0, 0, 0, 0);
    send_op(rtss_pkg::OP_SORT, 0, 0, 0, 0, 0);
    send_op(rtss_pkg::OP_SEARCH, 0, 0, 0, 0, 0);
    send_op(rtss_pkg::OP_READ, 0, 0, 0, 0, 4'hF);
    send_op(rtss_pkg::OP_APPEND, 0, 0, 8'd0, 14'd0, 0);
    send_op(rtss_pkg::OP_STAGE, 0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 14'h3FFF, 4'hF);
    send_op(rtss_pkg::OP_STAGE, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
    send_op(rtss_pkg::OP_STAGE, 2, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
    send_op(rtss_pkg::OP_STAGE, 3, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
    send_op(rtss_pkg::OP_APPEND, 3, 0, 8'hFF, 14'd10000, 0);
    send_op(rtss_pkg::OP_APPEND, 0, 0, 8'd7, 14'h3FFF, 0);
    send_op(rtss_pkg::OP_SEARCH, 0, 0, 0, 0, 0);
    send_op(rtss_pkg::OP_STAGE, 1, 64'h0000_0000_0000_0041, 0, 0, 0);
    send_op(rtss_pkg::OP_SEARCH, 0, 0, 0, 0, 0);
    send_op(rtss_pkg::OP_STAGE, 0, 64'h0, 0, 0, 0);
    send_op(rtss_pkg::OP_SEARCH, 0, 0, 0, 0, 0);
    send_op(rtss_pkg::OP_READ, 3, 0, 0, 0, 4'd1);
    send_op(rtss_pkg::OP_READ, 0, 0, 0, 0, 4'd2);
    for (int i = 0; i < 15; i++)
      send_op(rtss_pkg::OP_APPEND, 0, 0, 8'($urandom), 14'($urandom_range(10000)), 0);
    send_op(rtss_pkg::OP_SORT, 0, 0, 0, 0, 0);
    send_op(rtss_pkg::OP_READ, 2, 0, 0, 0, 4'hF);
    send_op(3'd6, 0, 0, 0, 0, 0);
    send_op(3'd7, 3, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 14'h3FFF, 4'hF);
    drain_results();

    // long receiver hold-off while items keep arriving
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) random_item();
    join
    drain_results();

    // idling phases over the random part
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int i = 0; i < 40; i++) random_item();
      drain_results();
    end

    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rtss_pkg.sv
hw/rtl/rtss_div.sv
hw/rtl/record_table_sort_search_unit.sv
tb/sv/record_table_checker.sv
tb/sv/tb_record_table_sort_search_unit.sv
